// ===== sv/vts_pkg.sv =====
// shared types and constants for the vertex to screen transform
`timescale 1ns / 1ps
package vts_pkg;

    // request kinds
    localparam logic REQ_POINT = 1'b0;
    localparam logic REQ_LOAD  = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_STAGES = 2'd2;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PICK,
        ST_MAC,
        ST_ROW,
        ST_DIV,
        ST_DIVRUN,
        ST_NEXTDIV,
        ST_SCALE,
        ST_OUT
    } vts_state_t;

    // store access request from the sequencer
    typedef struct packed {
        logic       wr_en;
        logic [5:0] addr;
        logic [31:0] wdata;
    } vts_mem_req_t;

endpackage

// ===== sv/vts_coef_ram.sv =====
// coefficient store: single port synchronous memory, registered read data
`timescale 1ns / 1ps
module vts_coef_ram (
    input  logic                  aclk,
    input  vts_pkg::vts_mem_req_t req,
    output logic [31:0]           rdata
);

    logic [31:0] mem [64];
    logic [31:0] rdata_reg;

    // write or read one entry per cycle
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= req.wdata;
        end
        rdata_reg <= mem[req.addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/vts_divider.sv =====
// signed restoring divider: quotient = (num << FRAC_BITS) / den, toward zero, saturated
`timescale 1ns / 1ps
module vts_divider #(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [31:0] quot
);

    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] dvd_reg, dvd_next;
    logic [NW-1:0] q_reg, q_next;
    logic [32:0]   rem_reg, rem_next;
    logic [31:0]   dvs_reg, dvs_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [32:0]   trial;
    logic [NW:0]   sq;
    logic [NW:0]   mag_num;
    logic [32:0]   mag_den;

    // one quotient bit per cycle
    always_comb begin
        mag_num  = {{(FRAC_BITS+1){1'b0}}, num} << FRAC_BITS;
        if (num[31]) begin
            mag_num = ({{(FRAC_BITS+1){1'b0}}, ~num} + 1'b1) << FRAC_BITS;
        end
        mag_den  = den[31] ? ({1'b0, ~den} + 33'd1) : {1'b0, den};
        dvd_next = dvd_reg;
        q_next   = q_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial    = {rem_reg[31:0], dvd_reg[NW-1]} - {1'b0, dvs_reg};
        if (start) begin
            dvd_next  = mag_num[NW-1:0];
            dvs_next  = mag_den[31:0];
            neg_next  = num[31] ^ den[31];
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = dvd_reg << 1;
            if (!trial[32]) begin
                rem_next = trial;
                q_next   = {q_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[31:0], dvd_reg[NW-1]};
                q_next   = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
    end

    // sign and saturate
    always_comb begin
        sq = neg_reg ? -{1'b0, q_reg} : {1'b0, q_reg};
        if (!neg_reg && q_reg > NW'(32'h7FFF_FFFF)) begin
            quot = 32'h7FFF_FFFF;
        end else if (neg_reg && q_reg > NW'(33'h8000_0000)) begin
            quot = 32'h8000_0000;
        end else begin
            quot = sq[31:0];
        end
    end

    assign done = done_reg;

endmodule

// ===== sv/vts_seq.sv =====
// sequencer: coefficient loads, matrix passes with one multiplier, divide and scaling
`timescale 1ns / 1ps
module vts_seq #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_req_type,
    input  logic signed [31:0]     s_pos_x,
    input  logic signed [31:0]     s_pos_y,
    input  logic signed [31:0]     s_pos_z,
    input  logic                   s_use_model,
    input  logic [1:0]             s_matrix_sel,
    input  logic [1:0]             s_coef_row,
    input  logic [1:0]             s_coef_col,
    input  logic signed [31:0]     s_coef_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [31:0]     m_screen_x,
    output logic signed [31:0]     m_screen_y,
    output logic signed [31:0]     m_depth,
    output logic                   m_w_zero,
    input  logic [15:0]            width,
    input  logic [15:0]            height,
    input  logic [2:0]             stages,
    output vts_pkg::vts_mem_req_t  mem_req,
    input  logic [31:0]            mem_rdata,
    output logic                   div_start,
    output logic [31:0]            div_num,
    output logic [31:0]            div_den,
    input  logic                   div_done,
    input  logic [31:0]            div_quot
);

    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    vts_pkg::vts_state_t st_reg, st_next;
    logic [31:0] v_reg [4];
    logic [31:0] v_next [4];
    logic [31:0] res_reg [4];
    logic [31:0] res_next [4];
    logic [3:0]  en_reg, en_next;
    logic [1:0]  mat_reg, mat_next;
    logic [1:0]  row_reg, row_next;
    logic [2:0]  col_reg, col_next;
    logic [1:0]  dix_reg, dix_next;
    logic [5:0]  clr_reg, clr_next;
    logic signed [65:0] acc_reg, acc_next;
    logic signed [63:0] prod;
    logic signed [65:0] acc_sh;
    logic [31:0] out_reg [3];
    logic [31:0] out_next [3];
    logic        wz_reg, wz_next;
    logic [31:0] hold_reg [3];
    logic [31:0] hold_next [3];
    logic        hold_wz_reg, hold_wz_next;
    logic        mv_reg, mv_next;
    logic signed [48:0] scl;
    logic signed [31:0] cval;
    logic [1:0]  pick;
    logic        found;

    // saturate to 32 bits
    function automatic logic [31:0] sat66(input logic signed [65:0] v);
        if (v > 66'sh7FFF_FFFF) begin
            sat66 = 32'h7FFF_FFFF;
        end else if (v < -66'sh8000_0000) begin
            sat66 = 32'h8000_0000;
        end else begin
            sat66 = v[31:0];
        end
    endfunction

    // clamp a loaded coefficient to the coefficient range
    always_comb begin
        cval = s_coef_value;
        if (COEF_WIDTH < 32) begin
            if (s_coef_value > (32'sd1 <<< (COEF_WIDTH - 1)) - 32'sd1) begin
                cval = (32'sd1 <<< (COEF_WIDTH - 1)) - 32'sd1;
            end else if (s_coef_value < -(32'sd1 <<< (COEF_WIDTH - 1))) begin
                cval = -(32'sd1 <<< (COEF_WIDTH - 1));
            end
        end
    end

    // lowest pending matrix
    always_comb begin
        pick  = 2'd0;
        found = 1'b0;
        for (int i = 3; i >= 0; i--) begin
            if (en_reg[i]) begin
                pick  = 2'(i);
                found = 1'b1;
            end
        end
    end

    assign prod   = $signed(mem_rdata) * $signed(v_reg[col_reg[1:0] - 2'd1]);
    assign acc_sh = acc_reg >>> FRAC_BITS;

    // next state and outputs
    always_comb begin
        st_next  = st_reg;
        v_next   = v_reg;
        res_next = res_reg;
        en_next  = en_reg;
        mat_next = mat_reg;
        row_next = row_reg;
        col_next = col_reg;
        dix_next = dix_reg;
        clr_next = clr_reg;
        acc_next = acc_reg;
        out_next = out_reg;
        wz_next  = wz_reg;
        hold_next    = hold_reg;
        hold_wz_next = hold_wz_reg;
        mv_next  = mv_reg;
        s_ready  = 1'b0;
        mem_req.wr_en = 1'b0;
        mem_req.addr  = {mat_reg, row_reg, col_reg[1:0]};
        mem_req.wdata = '0;
        div_start = 1'b0;
        div_num   = v_reg[dix_reg];
        div_den   = v_reg[3];
        scl       = '0;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        case (st_reg)
            vts_pkg::ST_CLEAR: begin
                mem_req.wr_en = 1'b1;
                mem_req.addr  = clr_reg;
                mem_req.wdata = (clr_reg[3:2] == clr_reg[1:0]) ? ONE : 32'd0;
                clr_next = clr_reg + 6'd1;
                if (clr_reg == 6'd63) begin
                    st_next = vts_pkg::ST_IDLE;
                end
            end
            vts_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_req_type == vts_pkg::REQ_LOAD) begin
                        mem_req.wr_en = 1'b1;
                        mem_req.addr  = {s_matrix_sel, s_coef_row, s_coef_col};
                        mem_req.wdata = cval;
                    end else begin
                        v_next[0] = s_pos_x;
                        v_next[1] = s_pos_y;
                        v_next[2] = s_pos_z;
                        v_next[3] = ONE;
                        en_next   = {stages, s_use_model};
                        st_next   = vts_pkg::ST_PICK;
                    end
                end
            end
            vts_pkg::ST_PICK: begin
                if (found) begin
                    mat_next = pick;
                    en_next[pick] = 1'b0;
                    row_next = 2'd0;
                    col_next = 3'd0;
                    acc_next = '0;
                    st_next  = vts_pkg::ST_MAC;
                end else begin
                    dix_next = 2'd0;
                    st_next  = vts_pkg::ST_DIV;
                end
            end
            vts_pkg::ST_MAC: begin
                // issue read for col_reg, accumulate the previous column
                if (col_reg != 3'd0) begin
                    acc_next = acc_reg + 66'(prod);
                end
                col_next = col_reg + 3'd1;
                if (col_reg == 3'd4) begin
                    st_next = vts_pkg::ST_ROW;
                end
            end
            vts_pkg::ST_ROW: begin
                res_next[row_reg] = sat66(acc_sh);
                acc_next = '0;
                col_next = 3'd0;
                row_next = row_reg + 2'd1;
                if (row_reg == 2'd3) begin
                    v_next  = res_next;
                    st_next = vts_pkg::ST_PICK;
                end else begin
                    st_next = vts_pkg::ST_MAC;
                end
            end
            vts_pkg::ST_DIV: begin
                if (v_reg[3] == 32'd0) begin
                    out_next[0] = '0;
                    out_next[1] = '0;
                    out_next[2] = '0;
                    wz_next = 1'b1;
                    st_next = vts_pkg::ST_OUT;
                end else begin
                    div_start = 1'b1;
                    st_next   = vts_pkg::ST_DIVRUN;
                end
            end
            vts_pkg::ST_DIVRUN: begin
                if (div_done) begin
                    out_next[dix_reg] = div_quot;
                    st_next = vts_pkg::ST_NEXTDIV;
                end
            end
            vts_pkg::ST_NEXTDIV: begin
                dix_next = dix_reg + 2'd1;
                st_next  = (dix_reg == 2'd2) ? vts_pkg::ST_SCALE : vts_pkg::ST_DIV;
            end
            vts_pkg::ST_SCALE: begin
                scl = $signed(out_reg[0]) * $signed({1'b0, width});
                if (width != 16'd0) begin
                    out_next[0] = sat66(66'(scl));
                end
                scl = $signed(out_reg[1]) * $signed({1'b0, height});
                if (height != 16'd0) begin
                    out_next[1] = sat66(66'(scl));
                end
                wz_next = 1'b0;
                st_next = vts_pkg::ST_OUT;
            end
            vts_pkg::ST_OUT: begin
                // move the finished point into the output register once it is free
                if (!mv_reg || m_ready) begin
                    hold_next    = out_reg;
                    hold_wz_next = wz_reg;
                    mv_next = 1'b1;
                    st_next = vts_pkg::ST_IDLE;
                end
            end
            default: st_next = vts_pkg::ST_IDLE;
        endcase
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= vts_pkg::ST_CLEAR;
            clr_reg <= '0;
            mv_reg  <= 1'b0;
            en_reg  <= '0;
        end else begin
            st_reg  <= st_next;
            clr_reg <= clr_next;
            mv_reg  <= mv_next;
            en_reg  <= en_next;
        end
        v_reg   <= v_next;
        res_reg <= res_next;
        mat_reg <= mat_next;
        row_reg <= row_next;
        col_reg <= col_next;
        dix_reg <= dix_next;
        acc_reg <= acc_next;
        out_reg <= out_next;
        wz_reg  <= wz_next;
        hold_reg    <= hold_next;
        hold_wz_reg <= hold_wz_next;
    end

    assign m_valid    = mv_reg;
    assign m_screen_x = hold_reg[0];
    assign m_screen_y = hold_reg[1];
    assign m_depth    = hold_reg[2];
    assign m_w_zero   = hold_wz_reg;

endmodule

// ===== sv/vertex_to_screen_transform_top.sv =====
// top level of the vertex to screen transform
//   channel   direction  handshake           beat
//   s_        in         s_valid / s_ready   load request or point
//   m_        out        m_valid / m_ready   screen x, y, depth, w_zero
//   cfg_      in         cfg_we              register write
// A load is written to the store as it is accepted. A point is accepted, then per enabled
// matrix comes a pick step and, per row, four store reads with multiply, one drain and one
// saturate; then one more pick step, the three divides in turn in the shared bit serial
// divider, and the scaling and output steps (divide and scaling are skipped when w is zero).
// After reset the store's 64 entries are filled with identity matrices; no s_ beat is taken
// meanwhile. A held result stalls only the output step of the next point.
`timescale 1ns / 1ps
module vertex_to_screen_transform_top #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic               s_use_model,
    input  logic [1:0]         s_matrix_sel,
    input  logic [1:0]         s_coef_row,
    input  logic [1:0]         s_coef_col,
    input  logic signed [31:0] s_coef_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_screen_x,
    output logic signed [31:0] m_screen_y,
    output logic signed [31:0] m_depth,
    output logic               m_w_zero,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic [2:0]  stages_reg;
    vts_pkg::vts_mem_req_t mem_req;
    logic [31:0] mem_rdata;
    logic        div_start, div_done;
    logic [31:0] div_num, div_den, div_quot;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= '0;
            height_reg <= '0;
            stages_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                vts_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                vts_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                vts_pkg::CFG_STAGES: stages_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    vts_coef_ram u_ram (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    vts_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    vts_seq #(.COEF_WIDTH(COEF_WIDTH), .FRAC_BITS(FRAC_BITS)) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_pos_z      (s_pos_z),
        .s_use_model  (s_use_model),
        .s_matrix_sel (s_matrix_sel),
        .s_coef_row   (s_coef_row),
        .s_coef_col   (s_coef_col),
        .s_coef_value (s_coef_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_screen_x   (m_screen_x),
        .m_screen_y   (m_screen_y),
        .m_depth      (m_depth),
        .m_w_zero     (m_w_zero),
        .width        (width_reg),
        .height       (height_reg),
        .stages       (stages_reg),
        .mem_req      (mem_req),
        .mem_rdata    (mem_rdata),
        .div_start    (div_start),
        .div_num      (div_num),
        .div_den      (div_den),
        .div_done     (div_done),
        .div_quot     (div_quot)
    );

endmodule
